FILE: hw/rtl/swmsd_pkg.sv
`timescale 1ns / 1ps
// Shared constants and width helpers for the sliding window mean/deviation block.
// No dependencies; imported by the front, back and top-level modules.

package swmsd_pkg;

    // Defaults for the top-level parameters
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Window length register and fill count
    localparam int               LEN_W     = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;
    localparam int               LEN_MAX   = 127;

    // Result formats
    localparam int FRAC_BITS = 8;
    localparam int MEAN_W    = 24;
    localparam int SD_W      = 24;

    localparam int unsigned MEAN_POS_MAX = 32'd8388607;
    localparam int unsigned MEAN_NEG_MAG = 32'd8388608;
    localparam int unsigned SD_MAX       = 32'd8388608;

    // Square root operand: variance term saturated to 48 bits, then scaled by 2^16
    localparam int                   D_SAT_W    = 48;
    localparam logic [D_SAT_W-1:0]   D_SAT_MAX  = '1;
    localparam int                   ROOT_SHIFT = 16;
    localparam int                   ROOT_IN_W  = D_SAT_W + ROOT_SHIFT;
    localparam int                   ROOT_W     = ROOT_IN_W / 2;

    // Depth of the queue between front and back
    localparam int FIFO_DEPTH = 2;

    // Signed running sum: one sign bit beyond depth * largest sample magnitude
    function automatic int sum_width(int depth, int bits);
        return bits + $clog2(depth) + 1;
    endfunction

    // Unsigned running sum of squares
    function automatic int sq_width(int depth, int bits);
        return 2 * bits + $clog2(depth) - 1;
    endfunction

endpackage

FILE: hw/rtl/swmsd_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: quotient = floor(numer / denom).
// Standalone; used twice by swmsd_back (mean and deviation).

module swmsd_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg && cnt_reg == CNT_W'(NUM_W - 1)) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/swmsd_fifo.sv
`timescale 1ns / 1ps
// Small register queue carrying window snapshots from front to back.
// Standalone; depth comes from the instantiating module.

module swmsd_fifo #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output logic [DATA_W-1:0] rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/swmsd_front.sv
`timescale 1ns / 1ps
// Front end: window length register, sample store, running sums, snapshot push.
// Depends on swmsd_pkg.

module swmsd_front import swmsd_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [LEN_W-1:0]              cfg_window_length,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          q_push,
    input  logic                          q_full,
    output logic [LEN_W + sum_width(WINDOW_DEPTH, SAMPLE_BITS)
                  + sq_width(WINDOW_DEPTH, SAMPLE_BITS) - 1:0] q_data
);

    localparam int SUM_W   = sum_width(WINDOW_DEPTH, SAMPLE_BITS);
    localparam int SQ_W    = sq_width(WINDOW_DEPTH, SAMPLE_BITS);
    localparam int SQS_W   = 2 * SAMPLE_BITS - 1;
    localparam int PTR_W   = $clog2(WINDOW_DEPTH);
    localparam int CMP_W   = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;
    localparam int LEN_CAP = (WINDOW_DEPTH < LEN_MAX) ? WINDOW_DEPTH : LEN_MAX;

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_SQUARE = 3'b010,
        F_UPDATE = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [LEN_W-1:0]              len_reg;
    logic [PTR_W-1:0]              pos_reg;
    logic [LEN_W-1:0]              filled_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]               sq_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic [PTR_W-1:0]              pos_use_reg;
    logic                          full_reg;
    logic [SQS_W-1:0]              old_sq_reg;
    logic [SQS_W-1:0]              new_sq_reg;

    logic [SAMPLE_BITS-1:0]        store_mem [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0]        rd_data_reg;

    logic [LEN_W-1:0]              eff_len;
    logic [PTR_W-1:0]              pos_sel;
    logic [PTR_W-1:0]              pos_next;
    logic [LEN_W-1:0]              fill_next;
    logic signed [SUM_W-1:0]       sum_next;
    logic [SQ_W-1:0]               sq_next;
    logic signed [SUM_W-1:0]       old_ext;
    logic signed [SUM_W-1:0]       new_ext;
    logic signed [2*SAMPLE_BITS-1:0] old_sq_full;
    logic signed [2*SAMPLE_BITS-1:0] new_sq_full;
    logic signed [SAMPLE_BITS-1:0] rd_signed;
    logic                          s_fire;
    logic                          cfg_fire;
    logic                          update_fire;

    // Zero acts as one, anything above the store depth as the depth
    assign eff_len = (len_reg == '0) ? LEN_W'(1)
                   : (len_reg > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_reg;

    assign pos_sel  = (CMP_W'(pos_reg) >= CMP_W'(eff_len)) ? '0 : pos_reg;
    assign pos_next = (CMP_W'(pos_use_reg) + 1'b1 >= CMP_W'(eff_len)) ? '0
                    : pos_use_reg + 1'b1;

    assign cfg_ready   = state_reg == F_IDLE;
    assign s_ready     = (state_reg == F_IDLE) && !cfg_valid;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign s_fire      = s_valid && s_ready;
    assign update_fire = (state_reg == F_UPDATE) && !q_full;

    assign rd_signed   = $signed(rd_data_reg);
    assign old_sq_full = rd_signed * rd_signed;
    assign new_sq_full = sample_reg * sample_reg;

    assign old_ext   = full_reg ? SUM_W'(old_reg) : '0;
    assign new_ext   = SUM_W'(sample_reg);
    assign sum_next  = sum_reg - old_ext + new_ext;
    assign sq_next   = sq_reg - (full_reg ? SQ_W'(old_sq_reg) : '0) + SQ_W'(new_sq_reg);
    assign fill_next = full_reg ? filled_reg : filled_reg + 1'b1;

    assign q_push = update_fire;
    assign q_data = {fill_next, sum_next, sq_next};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_fire) state_next = F_SQUARE;
            end
            F_SQUARE: begin
                state_next = F_UPDATE;
            end
            F_UPDATE: begin
                if (!q_full) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            len_reg    <= LEN_RESET;
            pos_reg    <= '0;
            filled_reg <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                len_reg    <= cfg_window_length;
                pos_reg    <= '0;
                filled_reg <= '0;
                sum_reg    <= '0;
                sq_reg     <= '0;
            end else if (update_fire) begin
                pos_reg    <= pos_next;
                filled_reg <= fill_next;
                sum_reg    <= sum_next;
                sq_reg     <= sq_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg  <= s_sample;
            pos_use_reg <= pos_sel;
            full_reg    <= filled_reg >= eff_len;
        end
        if (state_reg == F_SQUARE) begin
            old_reg    <= rd_signed;
            old_sq_reg <= old_sq_full[SQS_W-1:0];
            new_sq_reg <= new_sq_full[SQS_W-1:0];
        end
    end

    // Sample store: read every cycle at the current slot, write on update
    always_ff @(posedge aclk) begin
        if (update_fire) begin
            store_mem[pos_use_reg] <= sample_reg;
        end
        rd_data_reg <= store_mem[pos_sel];
    end

endmodule

FILE: hw/rtl/swmsd_back.sv
`timescale 1ns / 1ps
// Back end: bit-serial products, integer square root, two dividers, output register.
// Depends on swmsd_pkg and swmsd_div.

module swmsd_back import swmsd_pkg::*; #(
    parameter int SUM_W = 23,
    parameter int SQ_W  = 37
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  logic [LEN_W+SUM_W+SQ_W-1:0]    q_data,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [LEN_W-1:0]               m_fill_count,
    output logic signed [MEAN_W-1:0]       m_mean,
    output logic [SD_W-1:0]                m_std_deviation
);

    localparam int ENTRY_W   = LEN_W + SUM_W + SQ_W;
    localparam int MUL_STEPS = (SUM_W > LEN_W) ? SUM_W : LEN_W;
    localparam int MC_W      = $clog2(MUL_STEPS + 1);
    localparam int P1_W      = SQ_W + LEN_W;
    localparam int P2_W      = 2 * SUM_W;
    localparam int D_W       = (P1_W > P2_W) ? P1_W : P2_W;
    localparam int DX_W      = (D_W > D_SAT_W) ? D_W : D_SAT_W + 1;
    localparam int MNUM_W    = SUM_W + FRAC_BITS;
    localparam int MQX_W     = (MNUM_W > MEAN_W + 1) ? MNUM_W : MEAN_W + 1;
    localparam int RC_W      = $clog2(ROOT_W);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL  = 5'b00010,
        B_DIFF = 5'b00100,
        B_SQRT = 5'b01000,
        B_DIV  = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [LEN_W-1:0]     n_reg;
    logic                 neg_reg;
    logic [D_W-1:0]       acc1_reg, mc1_reg, acc2_reg, mc2_reg;
    logic [LEN_W-1:0]     mp1_reg;
    logic [SUM_W-1:0]     mp2_reg;
    logic [MC_W-1:0]      mul_cnt_reg;
    logic [ROOT_IN_W-1:0] x_reg, res_reg, bit_reg;
    logic [RC_W-1:0]      root_cnt_reg;
    logic                 m_valid_reg;
    logic [LEN_W-1:0]     fill_out_reg;
    logic [MEAN_W-1:0]    mean_out_reg;
    logic [SD_W-1:0]      sd_out_reg;

    logic [LEN_W-1:0]        in_fill;
    logic signed [SUM_W-1:0] in_sum;
    logic [SQ_W-1:0]         in_sq;
    logic [SUM_W-1:0]        in_mag;
    logic                    load;
    logic                    mul_last;
    logic                    root_last;
    logic [D_W-1:0]          diff;
    logic [DX_W-1:0]         diff_x;
    logic [D_SAT_W-1:0]      diff_sat;
    logic [ROOT_IN_W-1:0]    trial, x_next, res_next;
    logic                    root_ge;
    logic                    mean_done, sd_done;
    logic [MNUM_W-1:0]       mean_q;
    logic [ROOT_W-1:0]       sd_q;
    logic [MQX_W-1:0]        mean_qx;
    logic [MEAN_W-1:0]       mean_val;
    logic [SD_W-1:0]         sd_val;
    logic                    out_fire;

    assign in_fill = q_data[ENTRY_W-1 -: LEN_W];
    assign in_sum  = $signed(q_data[SUM_W+SQ_W-1 -: SUM_W]);
    assign in_sq   = q_data[SQ_W-1:0];
    assign in_mag  = in_sum[SUM_W-1] ? (~in_sum + 1'b1) : in_sum;

    assign load      = (state_reg == B_IDLE) && !q_empty;
    assign q_pop     = load;
    assign mul_last  = mul_cnt_reg == MC_W'(MUL_STEPS - 1);
    assign root_last = root_cnt_reg == RC_W'(ROOT_W - 1);

    // n*sum_sq - sum^2, never negative for a consistent window, saturated for the root
    assign diff     = (acc1_reg > acc2_reg) ? acc1_reg - acc2_reg : '0;
    assign diff_x   = DX_W'(diff);
    assign diff_sat = (diff_x > DX_W'(D_SAT_MAX)) ? D_SAT_MAX : diff_x[D_SAT_W-1:0];

    // One step of the digit-by-digit square root; res is a multiple of 2*bit,
    // so res + bit has no carry
    assign trial    = res_reg | bit_reg;
    assign root_ge  = x_reg >= trial;
    assign x_next   = root_ge ? x_reg - trial : x_reg;
    assign res_next = root_ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;

    swmsd_div #(
        .NUM_W (MNUM_W),
        .DEN_W (LEN_W)
    ) u_mean_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (load),
        .numer    ({in_mag, FRAC_BITS'(0)}),
        .denom    (in_fill),
        .done     (mean_done),
        .quotient (mean_q)
    );

    swmsd_div #(
        .NUM_W (ROOT_W),
        .DEN_W (LEN_W)
    ) u_sd_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    ((state_reg == B_SQRT) && root_last),
        .numer    (res_next[ROOT_W-1:0]),
        .denom    (n_reg),
        .done     (sd_done),
        .quotient (sd_q)
    );

    // Truncation toward zero: divide the magnitude, then restore the sign
    assign mean_qx = MQX_W'(mean_q);
    always_comb begin
        if (neg_reg) begin
            mean_val = (mean_qx > MQX_W'(MEAN_NEG_MAG)) ? MEAN_W'(MEAN_NEG_MAG)
                     : MEAN_W'(0) - mean_qx[MEAN_W-1:0];
        end else begin
            mean_val = (mean_qx > MQX_W'(MEAN_POS_MAX)) ? MEAN_W'(MEAN_POS_MAX)
                     : mean_qx[MEAN_W-1:0];
        end
    end

    assign sd_val = (sd_q > ROOT_W'(SD_MAX)) ? SD_W'(SD_MAX) : sd_q[SD_W-1:0];

    assign out_fire = (state_reg == B_DIV) && mean_done && sd_done
                    && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (load) state_next = B_MUL;
            end
            B_MUL: begin
                if (mul_last) state_next = B_DIFF;
            end
            B_DIFF: begin
                state_next = B_SQRT;
            end
            B_SQRT: begin
                if (root_last) state_next = B_DIV;
            end
            B_DIV: begin
                if (out_fire) state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                if (load) begin
                    n_reg       <= in_fill;
                    neg_reg     <= in_sum[SUM_W-1];
                    acc1_reg    <= '0;
                    acc2_reg    <= '0;
                    mc1_reg     <= D_W'(in_sq);
                    mp1_reg     <= in_fill;
                    mc2_reg     <= D_W'(in_mag);
                    mp2_reg     <= in_mag;
                    mul_cnt_reg <= '0;
                end
            end
            B_MUL: begin
                if (mp1_reg[0]) acc1_reg <= acc1_reg + mc1_reg;
                if (mp2_reg[0]) acc2_reg <= acc2_reg + mc2_reg;
                mc1_reg     <= mc1_reg << 1;
                mc2_reg     <= mc2_reg << 1;
                mp1_reg     <= mp1_reg >> 1;
                mp2_reg     <= mp2_reg >> 1;
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
            end
            B_DIFF: begin
                x_reg        <= {diff_sat, ROOT_SHIFT'(0)};
                res_reg      <= '0;
                bit_reg      <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
                root_cnt_reg <= '0;
            end
            B_SQRT: begin
                x_reg        <= x_next;
                res_reg      <= res_next;
                bit_reg      <= bit_reg >> 2;
                root_cnt_reg <= root_cnt_reg + 1'b1;
            end
            B_DIV: begin
                if (out_fire) begin
                    fill_out_reg <= n_reg;
                    mean_out_reg <= mean_val;
                    sd_out_reg   <= sd_val;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_fill_count    = fill_out_reg;
    assign m_mean          = $signed(mean_out_reg);
    assign m_std_deviation = sd_out_reg;

endmodule

FILE: hw/rtl/sliding_window_mean_stddev.sv
`timescale 1ns / 1ps
// Sliding window mean and population standard deviation over signed samples.
// Each accepted sample item enters a circular window of cfg_window_length entries
// (0 acts as 1, values above WINDOW_DEPTH act as WINDOW_DEPTH) and yields one result
// item: fill count, mean (signed, 8 fractional bits) and standard deviation
// (unsigned, 8 fractional bits), both truncated. Any write to the window length
// restarts the window empty; write it only while no item is in flight. The front
// handles one item at a time (store read, squares, sum update) and hands a snapshot
// of the running sums to the back through a 2-entry queue. The back is the slower
// part; for each item it runs queue pop, a bit-serial n*sum_sq and sum^2, root
// setup, a one-bit-per-cycle square root over 32 steps and a 32-step divide by
// the fill count, ending with divide done. The mean divide runs in parallel. A
// finished result sits in the output register while the back already works on
// the next item. No clearing pass after reset.
// Depends on swmsd_pkg, swmsd_front, swmsd_fifo, swmsd_back, swmsd_div.

module sliding_window_mean_stddev import swmsd_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Window length register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [LEN_W-1:0]              cfg_window_length,

    // Sample items in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,

    // Result items out
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [LEN_W-1:0]              m_fill_count,
    output logic signed [MEAN_W-1:0]      m_mean,
    output logic [SD_W-1:0]               m_std_deviation
);

    // Running sum widths follow the window depth and sample width
    localparam int SUM_W   = sum_width(WINDOW_DEPTH, SAMPLE_BITS);
    localparam int SQ_W    = sq_width(WINDOW_DEPTH, SAMPLE_BITS);
    localparam int ENTRY_W = LEN_W + SUM_W + SQ_W;

    // Snapshot of {fill count, running sum, running sum of squares} per item
    logic               q_push;
    logic               q_full;
    logic [ENTRY_W-1:0] q_wr_data;
    logic               q_pop;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_rd_data;

    // Front: register, sample store, running sums
    swmsd_front #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_window_length (cfg_window_length),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample          (s_sample),
        .q_push            (q_push),
        .q_full            (q_full),
        .q_data            (q_wr_data)
    );

    // Decoupling queue so front and back stall independently
    swmsd_fifo #(
        .DATA_W (ENTRY_W),
        .DEPTH  (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (q_rd_data)
    );

    // Back: statistics engine and output register
    swmsd_back #(
        .SUM_W (SUM_W),
        .SQ_W  (SQ_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_data          (q_rd_data),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fill_count    (m_fill_count),
        .m_mean          (m_mean),
        .m_std_deviation (m_std_deviation)
    );

endmodule
